// ===== src/sft_pkg.sv =====
// Shared types, constants and helpers of the subscriber table fan-out block.
package sft_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int IP_W      = 32;
    localparam int PORT_W    = 16;
    localparam int MODE_W    = 2;
    localparam int CHAN_W    = 2;
    localparam int TIME_W    = 32;
    localparam int TMO_W     = 16;
    localparam int MAXSESS_W = 7;

    localparam int IN_TDATA_W  = 88;
    localparam int OUT_TDATA_W = 48;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SESS = 1'd1;

    localparam logic [TMO_W-1:0]     TIMEOUT_RST  = 16'd15;
    localparam logic [MAXSESS_W-1:0] MAX_SESS_RST = 7'd64;

    // item kinds
    localparam logic OP_POLL   = 1'b0;
    localparam logic OP_PACKET = 1'b1;

    // packet channels
    localparam logic [CHAN_W-1:0] CH_THERMAL = 2'd0;
    localparam logic [CHAN_W-1:0] CH_VIS_MAIN = 2'd1;
    localparam logic [CHAN_W-1:0] CH_VIS_SUB  = 2'd2;

    typedef struct packed {
        logic [IP_W-1:0]   ip;
        logic [PORT_W-1:0] port;
        logic [TIME_W-1:0] poll_time;
        logic [MODE_W-1:0] mode;
    } t_entry;

    typedef struct packed {
        logic              op;
        logic [IP_W-1:0]   ip;
        logic [PORT_W-1:0] port;
        logic [MODE_W-1:0] mode;
        logic [CHAN_W-1:0] chan;
        logic [TIME_W-1:0] now;
    } t_item;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        t_entry           wr_data;
    } t_ram_req;

    typedef struct packed {
        logic              valid;
        logic [IP_W-1:0]   ip;
        logic [PORT_W-1:0] port;
        logic              last;
    } t_push;

    function automatic logic wants(input logic [MODE_W-1:0] mode,
                                   input logic [CHAN_W-1:0] chan);
        logic w;
        case (chan)
            CH_THERMAL:  w = mode[0];
            CH_VIS_MAIN: w = mode[1];
            CH_VIS_SUB:  w = mode[1];
            default:     w = 1'b0;
        endcase
        return w;
    endfunction

endpackage

// ===== src/sft_cfg.sv =====
// Configuration registers: idle timeout and session limit.
module sft_cfg
    import sft_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic [TMO_W-1:0]      o_timeout,
    output logic [MAXSESS_W-1:0]  o_max_sess
);

    logic [TMO_W-1:0]     r_timeout;
    logic [MAXSESS_W-1:0] r_max_sess;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout  <= TIMEOUT_RST;
            r_max_sess <= MAX_SESS_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TIMEOUT:  r_timeout  <= i_cfg_data[TMO_W-1:0];
                CFG_MAX_SESS: r_max_sess <= i_cfg_data[MAXSESS_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_timeout  = r_timeout;
    assign o_max_sess = r_max_sess;

endmodule

// ===== src/sft_ram.sv =====
// Subscriber table memory: one write port, one registered read port.
module sft_ram
    import sft_pkg::*;
(
    input  logic     i_clk,
    input  t_ram_req i_req,
    output t_entry   o_rd_data
);

    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/sft_out.sv =====
// Output register for destination results.
module sft_out
    import sft_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_push                  i_push,
    output logic                   o_free,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [OUT_TDATA_W-1:0] o_data,
    output logic                   o_last
);

    logic                   r_valid;
    logic [OUT_TDATA_W-1:0] r_data;
    logic                   r_last;

    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push.valid) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_data <= {i_push.port, i_push.ip};
            r_last <= i_push.last;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_last  = r_last;

endmodule

// ===== src/sft_walker.sv =====
// Table walk sequencer: poll lookup and append, packet aging, compaction and fan-out.
module sft_walker
    import sft_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  t_item                i_item,
    input  logic [TMO_W-1:0]     i_timeout,
    input  logic [MAXSESS_W-1:0] i_max_sess,
    output t_ram_req             o_req,
    input  t_entry               i_rd_data,
    output t_push                o_push,
    input  logic                 i_out_free
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_EVAL,
        S_APPEND,
        S_FLUSH
    } t_state;

    t_state            r_state, n_state;
    t_item             r_item, n_item;
    logic [CNT_W-1:0]  r_i, n_i;
    logic [CNT_W-1:0]  r_w, n_w;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_pend_v, n_pend_v;
    logic [IP_W-1:0]   r_pend_ip, n_pend_ip;
    logic [PORT_W-1:0] r_pend_port, n_pend_port;

    logic [CNT_W-1:0]  limit;
    logic [CNT_W-1:0]  i_next;
    logic [TIME_W-1:0] idle;
    logic              hit, live, want;

    assign limit  = (i_max_sess < CNT_W'(TABLE_DEPTH)) ? i_max_sess[CNT_W-1:0]
                                                       : CNT_W'(TABLE_DEPTH);
    assign i_next = r_i + CNT_W'(1);
    assign idle   = r_item.now - i_rd_data.poll_time;
    assign live   = idle <= {{(TIME_W-TMO_W){1'b0}}, i_timeout};
    assign hit    = (i_rd_data.ip == r_item.ip) && (i_rd_data.port == r_item.port);
    assign want   = wants(i_rd_data.mode, r_item.chan);

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_i         = r_i;
        n_w         = r_w;
        n_count     = r_count;
        n_pend_v    = r_pend_v;
        n_pend_ip   = r_pend_ip;
        n_pend_port = r_pend_port;
        o_req       = '0;
        o_push      = '0;
        o_ready     = (r_state == S_IDLE);

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_item = i_item;
                    n_i    = '0;
                    n_w    = '0;
                    if (r_count != '0) begin
                        n_state = S_RD;
                    end else if (i_item.op == OP_POLL) begin
                        n_state = S_APPEND;
                    end else begin
                        n_state = S_FLUSH;
                    end
                end
            end
            S_RD: begin
                o_req.rd_en   = 1'b1;
                o_req.rd_addr = r_i[IDX_W-1:0];
                n_state       = S_EVAL;
            end
            S_EVAL: begin
                if (r_item.op == OP_POLL) begin
                    if (hit) begin
                        o_req.wr_en   = 1'b1;
                        o_req.wr_addr = r_i[IDX_W-1:0];
                        o_req.wr_data = '{ip: r_item.ip, port: r_item.port,
                                          poll_time: r_item.now, mode: r_item.mode};
                        n_state       = S_IDLE;
                    end else begin
                        n_i     = i_next;
                        n_state = (i_next == r_count) ? S_APPEND : S_RD;
                    end
                end else if (!(live && want && r_pend_v && !i_out_free)) begin
                    // close up the table: live entries move down to the write index
                    if (live) begin
                        o_req.wr_en   = 1'b1;
                        o_req.wr_addr = r_w[IDX_W-1:0];
                        o_req.wr_data = i_rd_data;
                        n_w           = r_w + CNT_W'(1);
                        if (want) begin
                            o_push.valid = r_pend_v;
                            o_push.ip    = r_pend_ip;
                            o_push.port  = r_pend_port;
                            o_push.last  = 1'b0;
                            n_pend_v     = 1'b1;
                            n_pend_ip    = i_rd_data.ip;
                            n_pend_port  = i_rd_data.port;
                        end
                    end
                    n_i     = i_next;
                    n_state = (i_next == r_count) ? S_FLUSH : S_RD;
                end
            end
            S_APPEND: begin
                if (r_count < limit) begin
                    o_req.wr_en   = 1'b1;
                    o_req.wr_addr = r_count[IDX_W-1:0];
                    o_req.wr_data = '{ip: r_item.ip, port: r_item.port,
                                      poll_time: r_item.now, mode: r_item.mode};
                    n_count       = r_count + CNT_W'(1);
                end
                n_state = S_IDLE;
            end
            S_FLUSH: begin
                n_count = r_w;
                // hold the final destination until the output register has room
                if (r_pend_v) begin
                    if (i_out_free) begin
                        o_push.valid = 1'b1;
                        o_push.ip    = r_pend_ip;
                        o_push.port  = r_pend_port;
                        o_push.last  = 1'b1;
                        n_pend_v     = 1'b0;
                        n_state      = S_IDLE;
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_pend_v <= 1'b0;
            r_i      <= '0;
            r_w      <= '0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_pend_v <= n_pend_v;
            r_i      <= n_i;
            r_w      <= n_w;
        end
        r_item      <= n_item;
        r_pend_ip   <= n_pend_ip;
        r_pend_port <= n_pend_port;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.valid |-> i_out_free)
        else $error("result pushed into a full output register");

    a_compact_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL) |-> (r_w <= r_i))
        else $error("compaction write index ahead of read index");

    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend_v)
        else $error("destination left pending after the walk");

endmodule

// ===== src/subscriber_table_fanout.sv =====
// Top level of the subscriber table fan-out block.
//
//  channel   direction  handshake                     payload
//  s_axis    in         s_axis_tvalid/s_axis_tready   tdata: item fields, tuser: op
//  m_axis    out        m_axis_tvalid/m_axis_tready   tdata: dest_ip, dest_port; tlast
//  cfg       in         i_cfg_valid/o_cfg_ready       i_cfg_index, i_cfg_data
//
//  A poll scans the stored entries until one matches and appends when none does; a packet
//  walks every stored entry, and a table holds up to 64 entries. Each entry is read and
//  then evaluated around the registered-read table memory; no new item is taken until then.
//  Reset clears the entry count but not the table memory, which needs no clearing pass.
//  A full output register holds the walk until the result is transferred.
module subscriber_table_fanout
    import sft_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [31:0] remote_ip, [47:32] remote_port, [49:48] stream_mode,
    // [51:50] channel, [83:52] now_seconds, [87:84] zero
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // [0] op
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [31:0] dest_ip, [47:32] dest_port
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                   m_axis_tlast,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_item                item;
    t_ram_req             req;
    t_entry               rd_data;
    t_push                push;
    logic                 out_free;
    logic [TMO_W-1:0]     timeout;
    logic [MAXSESS_W-1:0] max_sess;

    assign item.op   = s_axis_tuser;
    assign item.ip   = s_axis_tdata[31:0];
    assign item.port = s_axis_tdata[47:32];
    assign item.mode = s_axis_tdata[49:48];
    assign item.chan = s_axis_tdata[51:50];
    assign item.now  = s_axis_tdata[83:52];

    sft_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_timeout   (timeout),
        .o_max_sess  (max_sess)
    );

    sft_ram u_ram (
        .i_clk     (i_clk),
        .i_req     (req),
        .o_rd_data (rd_data)
    );

    sft_walker u_walker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_item     (item),
        .i_timeout  (timeout),
        .i_max_sess (max_sess),
        .o_req      (req),
        .i_rd_data  (rd_data),
        .o_push     (push),
        .i_out_free (out_free)
    );

    sft_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_free  (out_free),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata),
        .o_last  (m_axis_tlast)
    );

endmodule
